// ----- design/huffman_code_builder_top_defines.svh -----
// Assertion macros shared by the code builder modules.
`ifndef HUFFMAN_CODE_BUILDER_TOP_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define HCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define HCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/hcb_pkg.sv -----
package hcb_pkg;

  localparam int unsigned MaxSymbols = 32;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned EntryCount = 2 * MaxSymbols - 1;
  localparam int unsigned IdxW = $clog2(EntryCount);
  localparam int unsigned CntW = $clog2(MaxSymbols + 1);
  localparam int unsigned SumW = WeightBits + $clog2(MaxSymbols);
  localparam int unsigned CodeW = 63;
  localparam int unsigned LenW = 6;
  localparam int unsigned StackDepth = 2 * MaxSymbols;
  localparam int unsigned SpW = $clog2(StackDepth + 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_MERGE,
    ST_SINGLE,
    ST_POP,
    ST_READ,
    ST_VISIT,
    ST_EMIT,
    ST_CLEAR
  } hcb_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the accepted request
    logic scan_start; // restart the minimum scan
    logic scan_step;  // examine one entry
    logic take_a;     // retire the first minimum
    logic take_b;     // retire the second minimum
    logic merge;      // write the merged node
    logic init_trav;  // push the root
    logic pop;        // pop the stack top
    logic visit;      // expand or emit the popped entry
    logic single;     // load the single-symbol result
    logic clear;      // end of a set
  } hcb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic merges_done;
    logic one_symbol;
    logic no_symbol;
    logic is_leaf;
    logic stack_empty;
  } hcb_status_t;

endpackage

// ----- design/hcb_ctrl.sv -----
module hcb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_last_symbol_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hcb_pkg::hcb_cmd_t    cmd_o,
  input  hcb_pkg::hcb_status_t sts_i
);
  import hcb_pkg::*;
  `include "huffman_code_builder_top_defines.svh"

  hcb_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_symbol_i) begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        // Pick the build path once the final request is stored.
        if (sts_i.no_symbol) begin
          cmd_o.clear = 1'b1;
          state_d = ST_LOAD;
        end else if (sts_i.one_symbol) begin
          cmd_o.single = 1'b1;
          state_d = ST_SINGLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN_A;
        end
      end
      ST_SCAN_A: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.take_a = 1'b1;
          state_d = ST_SCAN_B;
        end
      end
      ST_SCAN_B: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.take_b = 1'b1;
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        if (sts_i.merges_done) begin
          cmd_o.init_trav = 1'b1;
          state_d = ST_POP;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = ST_SCAN_A;
        end
      end
      ST_SINGLE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.clear = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_POP: begin
        if (sts_i.stack_empty) begin
          cmd_o.clear = 1'b1;
          state_d = ST_LOAD;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // Memory read latency for the popped entry.
        state_d = ST_VISIT;
      end
      ST_VISIT: begin
        cmd_o.visit = 1'b1;
        state_d = sts_i.is_leaf ? ST_EMIT : ST_POP;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_POP;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  `HCB_ASSERT_IMP(a_out_not_loading, clk_i, rst_ni, out_valid_o, in_stall_o,
    "result offered while loading")
  `HCB_ASSERT_NEXT(a_emit_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o, "result dropped under stall")
  `HCB_ASSERT_IMP(a_one_take, clk_i, rst_ni, cmd_o.take_a, !cmd_o.take_b,
    "two minima retired at once")
endmodule

// ----- design/hcb_datapath.sv -----
module hcb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hcb_pkg::hcb_cmd_t                    cmd_i,
  output hcb_pkg::hcb_status_t                 sts_o,
  input  logic [7:0]                          symbol_i,
  input  logic [15:0]                         weight_i,
  output logic [7:0]                          code_symbol_o,
  output logic [62:0]                         code_o,
  output logic [5:0]                          code_length_o,
  output logic                                last_code_o
);
  import hcb_pkg::*;
  `include "huffman_code_builder_top_defines.svh"

  logic [7:0]       leaf_mem   [MaxSymbols];
  logic [SumW-1:0]  weight_mem [EntryCount];
  logic [IdxW-1:0]  left_mem   [MaxSymbols-1];
  logic [IdxW-1:0]  right_mem  [MaxSymbols-1];
  logic [EntryCount-1:0] live_q;
  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  total_q;
  logic [IdxW-1:0]  merge_q;

  // Scan registers.
  logic [IdxW:0]    scan_q;
  logic             found_q;
  logic [IdxW-1:0]  best_q;
  logic [SumW-1:0]  best_w_q;
  logic [IdxW-1:0]  a_q, b_q;
  logic [SumW-1:0]  a_w_q, b_w_q;
  logic [IdxW-1:0]  scan_idx;
  logic [SumW-1:0]  scan_w_q;
  logic             scan_live_q;
  logic [IdxW:0]    scan_rd_q;

  // Traversal stack.
  logic [IdxW-1:0]  stk_node [StackDepth];
  logic [CodeW-1:0] stk_code [StackDepth];
  logic [LenW-1:0]  stk_len  [StackDepth];
  logic [SpW-1:0]   sp_q;
  logic [IdxW-1:0]  nd_q;
  logic [CodeW-1:0] code_q;
  logic [LenW-1:0]  len_q;
  logic [7:0]       sym_rd_q;
  logic [IdxW-1:0]  lch_rd_q, rch_rd_q;
  logic             is_leaf;
  logic [IdxW-1:0]  m_idx;
  logic             can_push;

  assign scan_idx  = scan_q[IdxW-1:0];

  // Scan pipeline: read one weight per cycle, compare it in the cycle after.
  always_ff @(posedge clk_i) begin
    scan_w_q <= weight_mem[scan_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      scan_rd_q   <= '0;
      scan_live_q <= 1'b0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan_start || cmd_i.take_a) begin
      scan_q      <= '0;
      scan_rd_q   <= '0;
      scan_live_q <= 1'b0;
      found_q     <= 1'b0;
    end else if (cmd_i.scan_step) begin
      scan_q      <= scan_q + 1'b1;
      scan_rd_q   <= scan_q;
      scan_live_q <= (scan_q < {1'b0, total_q}) && live_q[scan_idx];
      if (scan_live_q && (!found_q || scan_w_q < best_w_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  // The compared weight belongs to the entry held in scan_rd_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && scan_live_q && (!found_q || scan_w_q < best_w_q)) begin
      best_q   <= scan_rd_q[IdxW-1:0];
      best_w_q <= scan_w_q;
    end
  end

  // The compare stage runs behind the read: a done scan has examined entries below total.
  assign sts_o.scan_done = scan_q > {1'b0, total_q} && !scan_live_q;
  // A set of n symbols needs n-1 merges; the last one has index n-2.
  assign sts_o.merges_done = (merge_q == count_q[IdxW-1:0] - IdxW'(2));
  assign sts_o.one_symbol  = (count_q == CntW'(1));
  assign sts_o.no_symbol   = (count_q == '0);
  assign sts_o.stack_empty = (sp_q == '0);
  assign sts_o.is_leaf     = is_leaf;
  assign is_leaf = ({1'b0, nd_q} < {1'b0, count_q[IdxW-1:0]}) || (count_q == CntW'(MaxSymbols)
                   && nd_q < IdxW'(MaxSymbols));

  // Minimum picks and merges.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_a) begin
      a_q <= best_q;
      a_w_q <= best_w_q;
    end
    if (cmd_i.take_b) begin
      b_q <= best_q;
      b_w_q <= best_w_q;
    end
  end

  // Entry stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CntW'(MaxSymbols)) begin
      leaf_mem[count_q[IdxW-2:0]] <= symbol_i;
      weight_mem[IdxW'(count_q)] <= SumW'(weight_i[WeightBits-1:0]);
    end
    if (cmd_i.merge) begin
      weight_mem[total_q] <= a_w_q + b_w_q;
      left_mem[merge_q[IdxW-2:0]]  <= a_q;
      right_mem[merge_q[IdxW-2:0]] <= b_q;
    end
  end

  // Control registers of the set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= '0;
      count_q <= '0;
      total_q <= '0;
      merge_q <= '0;
    end else begin
      if (cmd_i.load && count_q < CntW'(MaxSymbols)) begin
        live_q[IdxW'(count_q)] <= 1'b1;
        count_q <= count_q + 1'b1;
        total_q <= total_q + 1'b1;
      end
      if (cmd_i.take_a) live_q[best_q] <= 1'b0;
      if (cmd_i.take_b) live_q[best_q] <= 1'b0;
      if (cmd_i.merge) begin
        live_q[total_q] <= 1'b1;
        total_q <= total_q + 1'b1;
        merge_q <= merge_q + 1'b1;
      end
      if (cmd_i.clear) begin
        live_q  <= '0;
        count_q <= '0;
        total_q <= '0;
        merge_q <= '0;
      end
    end
  end

  // Node read for the popped entry.
  assign m_idx = nd_q - count_q[IdxW-1:0];
  always_ff @(posedge clk_i) begin
    sym_rd_q <= leaf_mem[nd_q[IdxW-2:0]];
    lch_rd_q <= left_mem[m_idx[IdxW-2:0]];
    rch_rd_q <= right_mem[m_idx[IdxW-2:0]];
  end

  assign can_push = (len_q < LenW'(CodeW));

  // Depth-first traversal stack.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.init_trav) begin
      sp_q <= SpW'(1);
    end else if (cmd_i.pop) begin
      sp_q <= sp_q - 1'b1;
    end else if (cmd_i.visit && !is_leaf && can_push) begin
      sp_q <= sp_q + SpW'(2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_trav) begin
      stk_node[0] <= total_q;
      stk_code[0] <= '0;
      stk_len[0]  <= '0;
    end else if (cmd_i.pop) begin
      nd_q   <= stk_node[sp_q[SpW-2:0] - 1'b1];
      code_q <= stk_code[sp_q[SpW-2:0] - 1'b1];
      len_q  <= stk_len[sp_q[SpW-2:0] - 1'b1];
    end else if (cmd_i.visit && !is_leaf && can_push) begin
      stk_node[sp_q[SpW-2:0]]        <= rch_rd_q;
      stk_code[sp_q[SpW-2:0]]        <= {code_q[CodeW-2:0], 1'b1};
      stk_len[sp_q[SpW-2:0]]         <= len_q + 1'b1;
      stk_node[sp_q[SpW-2:0] + 1'b1] <= lch_rd_q;
      stk_code[sp_q[SpW-2:0] + 1'b1] <= {code_q[CodeW-2:0], 1'b0};
      stk_len[sp_q[SpW-2:0] + 1'b1]  <= len_q + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.single) begin
      code_symbol_o <= leaf_mem[0];
      code_o        <= '0;
      code_length_o <= LenW'(1);
      last_code_o   <= 1'b1;
    end else if (cmd_i.visit && is_leaf) begin
      code_symbol_o <= sym_rd_q;
      code_o        <= code_q;
      code_length_o <= len_q;
      last_code_o   <= (sp_q == '0);
    end
  end

  `HCB_ASSERT_IMP(a_merge_bound, clk_i, rst_ni, cmd_i.merge,
    merge_q < IdxW'(MaxSymbols - 1), "too many merges")
  `HCB_ASSERT_IMP(a_stack_bound, clk_i, rst_ni, cmd_i.visit,
    sp_q <= SpW'(StackDepth - 2) || is_leaf, "stack overflow")
  `HCB_ASSERT_NEXT(a_clear_empty, clk_i, rst_ni, cmd_i.clear,
    count_q == '0 && live_q == '0, "set not cleared")
endmodule

// ----- design/huffman_code_builder_top.sv -----
// Huffman code builder. Each request loads one (symbol, weight) pair; a
// request with last_symbol set closes the set (at most 32 pairs are kept,
// extra pairs are dropped) and starts the build. A build of n symbols runs
// n-1 merges; each merge takes two linear scans over all entries made so far
// (one entry a cycle) plus a write of the merged node; codes then leave in
// depth-first order, each tree node taking a traversal stack pop and its
// node-memory read, and each code is held while it is offered.
// Loading accepts one request per cycle and stalls from the last request
// until the final code has been taken.
module huffman_code_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic [15:0] weight_i,
  input  logic        last_symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_symbol_o,
  output logic [62:0] code_o,
  output logic [5:0]  code_length_o,
  output logic        last_code_o
);
  import hcb_pkg::*;

  hcb_cmd_t    cmd;
  hcb_status_t sts;

  hcb_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_last_symbol_i(last_symbol_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  hcb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .symbol_i     (symbol_i),
    .weight_i     (weight_i),
    .code_symbol_o(code_symbol_o),
    .code_o       (code_o),
    .code_length_o(code_length_o),
    .last_code_o  (last_code_o)
  );
endmodule
